[rtl/weighted_adjacency_edge_insert_top_defines.svh]
// assertion macros for the weighted adjacency edge insert checker
// no dependencies
`ifndef WEIGHTED_ADJACENCY_EDGE_INSERT_TOP_DEFINES_SVH
`define WEIGHTED_ADJACENCY_EDGE_INSERT_TOP_DEFINES_SVH

// antecedent holds, consequent holds in the same cycle
`define WAE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wae check failed");

// antecedent holds, consequent holds in the next cycle
`define WAE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wae check failed");

`endif

[rtl/wae_pkg.sv]
// types, constants and helpers for the weighted adjacency edge insert block
// no dependencies
`timescale 1ns / 1ps

package wae_pkg;

  localparam int NODES         = 64;
  localparam int MAX_NEIGHBORS = 16;
  localparam int WEIGHT_BITS   = 16;

  localparam int NODE_FIELD_W = 6;
  localparam int STATUS_W     = 2;
  localparam int OUT_WEIGHT_W = 16;
  localparam int OUT_SLOT_W   = 4;

  localparam int ID_W   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int SLOT_W = $clog2(MAX_NEIGHBORS);
  localparam int CNT_W  = $clog2(MAX_NEIGHBORS + 1);
  localparam int ADDR_W = ID_W + SLOT_W;
  localparam int NODE_CODES = 2 ** NODE_FIELD_W;

  typedef logic [NODE_CODES-1:0][ID_W-1:0] node_tab_t;

  // node field reduced to a node index
  function automatic node_tab_t make_node_tab();
    node_tab_t t;
    for (int i = 0; i < NODE_CODES; i++) begin
      t[i] = ID_W'(i % NODES);
    end
    return t;
  endfunction

  localparam node_tab_t NODE_TAB = make_node_tab();

  typedef enum logic [STATUS_W-1:0] {
    ST_INC  = 2'd0,
    ST_NEW  = 2'd1,
    ST_FULL = 2'd2
  } edge_status_t;

  typedef struct packed {
    logic [NODE_FIELD_W-1:0] node_a;
    logic [NODE_FIELD_W-1:0] node_b;
  } in_item_t;

  typedef struct packed {
    edge_status_t            status;
    logic [OUT_WEIGHT_W-1:0] edge_weight;
    logic [OUT_SLOT_W-1:0]   slot_in_a;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]        id;
    logic [WEIGHT_BITS-1:0] weight;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_CA,
    S_RD_CB,
    S_LAT_CB,
    S_SCAN_A,
    S_UPD_A,
    S_SCAN_B,
    S_UPD_B,
    S_APP_A,
    S_APP_B,
    S_DROP,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic cnt_sel_b;
    logic lat_ca;
    logic lat_cb;
    logic scan_init;
    logic scan_run;
    logic sel_b;
    logic upd;
    logic app_a;
    logic app_b;
    logic drop;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic room;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/wae_ctrl.sv]
// controller state machine for the weighted adjacency edge insert block
// depends on wae_pkg
`timescale 1ns / 1ps

module wae_ctrl import wae_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_RD_CA;
      S_RD_CA:  state_next = S_RD_CB;
      S_RD_CB:  state_next = S_LAT_CB;
      S_LAT_CB: state_next = S_SCAN_A;
      S_SCAN_A: begin
        if (stat.scan_done) begin
          if (stat.found) state_next = S_UPD_A;
          else if (stat.room) state_next = S_APP_A;
          else state_next = S_DROP;
        end
      end
      S_UPD_A:  state_next = S_SCAN_B;
      S_SCAN_B: begin
        if (stat.scan_done) begin
          state_next = stat.found ? S_UPD_B : S_DONE;
        end
      end
      S_UPD_B:  state_next = S_DONE;
      S_APP_A:  state_next = S_APP_B;
      S_APP_B:  state_next = S_DONE;
      S_DROP:   state_next = S_DONE;
      S_DONE:   if (stat.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_RD_CA: cmd.cnt_sel_b = 1'b0;
      S_RD_CB: begin
        cmd.lat_ca    = 1'b1;
        cmd.cnt_sel_b = 1'b1;
      end
      S_LAT_CB: begin
        cmd.lat_cb    = 1'b1;
        cmd.scan_init = 1'b1;
      end
      S_SCAN_A: cmd.scan_run = 1'b1;
      S_UPD_A: begin
        cmd.upd       = 1'b1;
        cmd.scan_init = 1'b1;
      end
      S_SCAN_B: begin
        cmd.scan_run = 1'b1;
        cmd.sel_b    = 1'b1;
      end
      S_UPD_B: begin
        cmd.upd   = 1'b1;
        cmd.sel_b = 1'b1;
      end
      S_APP_A:  cmd.app_a = 1'b1;
      S_APP_B:  cmd.app_b = 1'b1;
      S_DROP:   cmd.drop  = 1'b1;
      S_DONE:   cmd.load_out = stat.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

[rtl/wae_dp.sv]
// datapath: neighbour store, count store, list scan and result register
// depends on wae_pkg
`timescale 1ns / 1ps

module wae_dp import wae_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NEIGHBORS);

  function automatic logic [WEIGHT_BITS-1:0] bump(input logic [WEIGHT_BITS-1:0] w);
    return (w == {WEIGHT_BITS{1'b1}}) ? w : w + 1'b1;
  endfunction

  function automatic logic [OUT_WEIGHT_W-1:0] out_w(input logic [WEIGHT_BITS-1:0] w);
    logic [31:0] t;
    t = 32'(w);
    return t[OUT_WEIGHT_W-1:0];
  endfunction

  function automatic logic [OUT_SLOT_W-1:0] out_s(input logic [CNT_W-1:0] s);
    logic [31:0] t;
    t = 32'(s);
    return t[OUT_SLOT_W-1:0];
  endfunction

  // stores
  entry_t           ent_mem [NODES*MAX_NEIGHBORS];
  logic [CNT_W-1:0] cnt_mem [NODES];
  logic [NODES-1:0] cnt_vld;

  entry_t           ent_rd;
  logic [CNT_W-1:0] cnt_rd;
  logic             cnt_rd_vld;

  // item and scan registers
  logic [ID_W-1:0]        a, b;
  logic [CNT_W-1:0]       ca, cb;
  logic [CNT_W-1:0]       k;
  logic                   pend;
  logic [SLOT_W-1:0]      pk;
  logic                   found;
  logic [SLOT_W-1:0]      slot;
  logic [WEIGHT_BITS-1:0] hit_w;
  out_item_t              res;

  logic [CNT_W-1:0]  cnt_q, n_cur, n_raw, cbe;
  logic [ID_W-1:0]   node, target, cnt_addr;
  logic              self_edge, hit, issue;
  logic              ent_we, cnt_we;
  logic [ADDR_W-1:0] ent_raddr, ent_waddr;
  entry_t            ent_wdata;
  logic [ID_W-1:0]   cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;
  logic [CNT_W:0]    ca_plus2;

  assign self_edge = (a == b);
  assign node      = cmd.sel_b ? b : a;
  assign target    = cmd.sel_b ? a : b;
  assign n_raw     = cmd.sel_b ? cb : ca;
  assign n_cur     = (n_raw > CNT_MAX) ? CNT_MAX : n_raw;
  assign cnt_q     = cnt_rd_vld ? cnt_rd : '0;
  assign cnt_addr  = cmd.cnt_sel_b ? b : a;
  assign cbe       = self_edge ? (ca + 1'b1) : cb;
  assign ca_plus2  = {1'b0, ca} + (CNT_W+1)'(2);

  assign hit   = pend && !found && (ent_rd.id == target);
  assign issue = cmd.scan_run && !found && !hit && (k < n_cur);
  assign ent_raddr = {node, k[SLOT_W-1:0]};

  // write port of the neighbour store
  always_comb begin
    ent_we    = cmd.upd || cmd.app_a || cmd.app_b;
    ent_waddr = {node, slot};
    ent_wdata = '{id: target, weight: bump(hit_w)};
    if (cmd.app_a) begin
      ent_waddr = {a, ca[SLOT_W-1:0]};
      ent_wdata = '{id: b, weight: WEIGHT_BITS'(1)};
    end else if (cmd.app_b) begin
      ent_waddr = {b, cbe[SLOT_W-1:0]};
      ent_wdata = '{id: a, weight: WEIGHT_BITS'(1)};
    end
  end

  always_comb begin
    cnt_we    = cmd.app_a || cmd.app_b;
    cnt_waddr = cmd.app_b ? b : a;
    cnt_wdata = cmd.app_b ? (cbe + 1'b1) : (ca + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    ent_rd <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rd <= cnt_mem[cnt_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld    <= '0;
      cnt_rd_vld <= 1'b0;
    end else begin
      if (cnt_we) cnt_vld[cnt_waddr] <= 1'b1;
      cnt_rd_vld <= cnt_vld[cnt_addr];
    end
  end

  // item capture and counts
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      a <= NODE_TAB[in_item.node_a];
      b <= NODE_TAB[in_item.node_b];
    end
    if (cmd.lat_ca) ca <= cnt_q;
    if (cmd.lat_cb) cb <= cnt_q;
  end

  // list scan
  always_ff @(posedge clk) begin
    if (rst) begin
      k     <= '0;
      pend  <= 1'b0;
      found <= 1'b0;
    end else if (cmd.scan_init) begin
      k     <= '0;
      pend  <= 1'b0;
      found <= 1'b0;
    end else if (cmd.scan_run) begin
      pend <= issue;
      if (issue) k <= k + 1'b1;
      if (hit) found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_run && issue) pk <= k[SLOT_W-1:0];
    if (cmd.scan_run && hit) begin
      slot  <= pk;
      hit_w <= ent_rd.weight;
    end
  end

  // result
  always_ff @(posedge clk) begin
    if (cmd.upd && !cmd.sel_b) begin
      res <= '{status: ST_INC, edge_weight: out_w(bump(hit_w)),
               slot_in_a: out_s(CNT_W'(slot))};
    end else if (cmd.upd && cmd.sel_b && self_edge) begin
      res.edge_weight <= out_w(bump(hit_w));
    end else if (cmd.app_a) begin
      res <= '{status: ST_NEW, edge_weight: OUT_WEIGHT_W'(1), slot_in_a: out_s(ca)};
    end else if (cmd.drop) begin
      res <= '{status: ST_FULL, edge_weight: '0, slot_in_a: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_item <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    stat.scan_done = found || (!pend && (k >= n_cur));
    stat.found     = found;
    stat.room      = self_edge ? (ca_plus2 <= (CNT_W+1)'(MAX_NEIGHBORS))
                               : ((ca < CNT_MAX) && (cb < CNT_MAX));
    stat.out_free  = !out_valid || !out_stall;
  end

endmodule

[rtl/weighted_adjacency_edge_insert_top.sv]
// channel  dir  payload     fields
// in       in   in_item_t   node_a, node_b
// out      out  out_item_t  status, edge_weight, slot_in_a
//
// one item at a time; an existing edge is found by scanning both lists up to its slots,
// an append or a drop scans all of a's list; the time taken is set by these single-port
// list scans
// rst clears the controller, the list counts and the output valid
// a stalled result is held in the output register; the next item is taken meanwhile
// depends on wae_pkg, wae_ctrl, wae_dp
`timescale 1ns / 1ps

module weighted_adjacency_edge_insert_top import wae_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  wae_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  wae_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[rtl/wae_checker.sv]
// port-level checks for the weighted adjacency edge insert block, with bind
// depends on wae_pkg and weighted_adjacency_edge_insert_top_defines.svh
`timescale 1ns / 1ps
`include "weighted_adjacency_edge_insert_top_defines.svh"

module wae_checker import wae_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall && (in_item == in_item);

  `WAE_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_acc, in_stall)
  `WAE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_item))
  `WAE_ASSERT_SAME(a_full_zero, clk, rst, out_valid && (out_item.status == ST_FULL), (out_item.edge_weight == '0) && (out_item.slot_in_a == '0))
  `WAE_ASSERT_SAME(a_new_weight_one, clk, rst, out_valid && (out_item.status == ST_NEW), out_item.edge_weight == OUT_WEIGHT_W'(1))
  `WAE_ASSERT_SAME(a_inc_nonzero, clk, rst, out_valid && (out_item.status == ST_INC), out_item.edge_weight != '0)

endmodule

bind weighted_adjacency_edge_insert_top wae_checker u_wae_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

[tb/edge_insert_sb_pkg.sv]
// scoreboard for the weighted adjacency edge insert block: own copy of the lists,
// predicted results in order of acceptance, whole-item checks with field by field reports
// depends on wae_pkg
`timescale 1ns / 1ps

package edge_insert_sb_pkg;
  import wae_pkg::*;

  class adjacency_tracker;
    logic [ID_W-1:0]        nbr_id [NODES][MAX_NEIGHBORS];
    logic [WEIGHT_BITS-1:0] nbr_wt [NODES][MAX_NEIGHBORS];
    int unsigned            nbr_cnt [NODES];
    out_item_t              pending_results [$];
    int                     errors;
    int                     n_inc;
    int                     n_new;
    int                     n_full;
    int                     peak_weight;

    function new();
      foreach (nbr_cnt[i]) nbr_cnt[i] = 0;
      errors      = 0;
      n_inc       = 0;
      n_new       = 0;
      n_full      = 0;
      peak_weight = 0;
    endfunction

    // first slot of node's list holding target, MAX_NEIGHBORS if absent
    function int slot_of(int node, int target);
      for (int k = 0; k < MAX_NEIGHBORS && k < int'(nbr_cnt[node]); k++) begin
        if (nbr_id[node][k] == ID_W'(target)) return k;
      end
      return MAX_NEIGHBORS;
    endfunction

    function logic [WEIGHT_BITS-1:0] bumped(logic [WEIGHT_BITS-1:0] w);
      return (&w) ? w : w + 1'b1;
    endfunction

    function void add_entry(int node, int id);
      if (nbr_cnt[node] >= MAX_NEIGHBORS) return;
      nbr_id[node][nbr_cnt[node]] = ID_W'(id);
      nbr_wt[node][nbr_cnt[node]] = 1;
      nbr_cnt[node]++;
    endfunction

    function out_item_t insert_edge(in_item_t it);
      int        a;
      int        b;
      int        sa;
      int        sb;
      bit        room;
      out_item_t r;
      a  = int'(it.node_a) % NODES;
      b  = int'(it.node_b) % NODES;
      sa = slot_of(a, b);
      if (sa < MAX_NEIGHBORS) begin
        nbr_wt[a][sa] = bumped(nbr_wt[a][sa]);
        sb = slot_of(b, a);
        if (sb < MAX_NEIGHBORS) nbr_wt[b][sb] = bumped(nbr_wt[b][sb]);
        r.status      = ST_INC;
        r.edge_weight = OUT_WEIGHT_W'(nbr_wt[a][sa]);
        r.slot_in_a   = OUT_SLOT_W'(sa);
        return r;
      end
      if (a == b) room = (nbr_cnt[a] + 2 <= MAX_NEIGHBORS);
      else room = (nbr_cnt[a] < MAX_NEIGHBORS) && (nbr_cnt[b] < MAX_NEIGHBORS);
      if (!room) begin
        r.status      = ST_FULL;
        r.edge_weight = '0;
        r.slot_in_a   = '0;
        return r;
      end
      r.slot_in_a = OUT_SLOT_W'(nbr_cnt[a]);
      add_entry(a, b);
      add_entry(b, a);
      r.status      = ST_NEW;
      r.edge_weight = OUT_WEIGHT_W'(1);
      return r;
    endfunction

    function void note_edge(in_item_t it);
      pending_results.push_back(insert_edge(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: result with none expected: status %0d weight %0d slot %0d",
                   got.status, got.edge_weight, got.slot_in_a);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: status %0d/%0d weight %0d/%0d slot %0d/%0d (expected/actual)",
                   want.status, got.status, want.edge_weight, got.edge_weight,
                   want.slot_in_a, got.slot_in_a);
      end
      case (want.status)
        ST_INC: begin
          n_inc++;
          if (int'(want.edge_weight) > peak_weight) peak_weight = int'(want.edge_weight);
        end
        ST_NEW:  n_new++;
        default: n_full++;
      endcase
    endfunction
  endclass

endpackage

[tb/tb.sv]
// top of the testbench for weighted_adjacency_edge_insert_top: directed edges
// and random edges under varied idling and back-pressure
// depends on wae_pkg, edge_insert_sb_pkg and the block itself
`timescale 1ns / 1ps

module tb;
  import wae_pkg::*;
  import edge_insert_sb_pkg::*;

  localparam int PHASE_ITEMS    = 467;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 60;

  logic      clk;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int sender_idle_pct = 0;
  int recv_idle_pct   = 0;
  bit hold_req        = 1'b0;
  int hold_left       = 0;
  int quiet_cycles    = 0;

  adjacency_tracker tracker = new();

  weighted_adjacency_edge_insert_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // output side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (rst) begin
        out_stall <= 1'b0;
      end else if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) tracker.check_result(out_item);
      if (in_valid && !in_stall) tracker.note_edge(in_item);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic drive_edge(int a, int b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{node_a: NODE_FIELD_W'(a), node_b: NODE_FIELD_W'(b)};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    in_item_t seen [$];
    in_item_t pick;
    int       a;
    int       b;
    int       r;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    sender_idle_pct = 24;
    recv_idle_pct   = 57;

    // extremes, repeats and a reversed edge
    drive_edge(0, 63);
    drive_edge(63, 0);
    drive_edge(0, 63);
    // self edge: two entries, then double increment
    drive_edge(5, 5);
    drive_edge(5, 5);
    drive_edge(5, 6);
    // nearly fill one list, a dropped self edge, a last append, drops both ways, increment on full list
    for (int k = 20; k < 35; k++) drive_edge(10, k);
    drive_edge(10, 10);
    drive_edge(10, 35);
    drive_edge(10, 36);
    drive_edge(36, 10);
    drive_edge(10, 20);

    for (int p = 0; p < 3; p++) begin
      sender_idle_pct = (p == 0) ? 24 : (p == 1) ? 57 : 0;
      recv_idle_pct   = (p == 0) ? 57 : (p == 1) ? 24 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == 100) hold_req = 1'b1;
        r = $urandom_range(99);
        if (r < 40) begin
          a = $urandom_range(11);
          b = $urandom_range(11);
        end else if (r < 50) begin
          a = $urandom_range(63);
          b = a;
        end else if (r < 65 && seen.size() > 0) begin
          pick = seen[$urandom_range(seen.size() - 1)];
          if ($urandom_range(1)) begin
            a = pick.node_a;
            b = pick.node_b;
          end else begin
            a = pick.node_b;
            b = pick.node_a;
          end
        end else begin
          a = $urandom() & 6'h3f;
          b = $urandom() & 6'h3f;
        end
        pick = '{node_a: NODE_FIELD_W'(a), node_b: NODE_FIELD_W'(b)};
        seen.push_back(pick);
        if (seen.size() > 64) void'(seen.pop_front());
        drive_edge(a, b);
      end
    end

    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("edges checked: %0d increments, %0d appends, %0d dropped on full lists",
             tracker.n_inc, tracker.n_new, tracker.n_full);
    $display("idling 24/57, 57/24 and none, one long output hold-off, peak weight %0d",
             tracker.peak_weight);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
